// ===== rtl/dchs_pkg.sv =====
// Shared types and constants for the CHS geometry block.
// Used by the divider cell, the divider row and the top level.
package dchs_pkg;
  localparam int unsigned NumW = 32;
  localparam int unsigned DivW = 6;
  localparam logic [NumW-1:0] LargeLimit = 32'd16383 * 32'd16 * 32'd63;
  localparam logic [14:0] LargeCyls = 15'd16383;
  localparam logic [4:0] LargeHeads = 5'd16;
  localparam logic [5:0] LargeSpt = 6'd63;
  localparam logic [NumW-1:0] MaxCyls = 32'd16384;

  // One restoring step travels from cell to cell.
  typedef struct packed {
    logic [DivW:0]   rem;
    logic [NumW-1:0] quo;
  } dchs_step_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HEAD, ST_SPT, ST_CYL, ST_DONE
  } dchs_state_t;
endpackage

// ===== rtl/dchs_cell.sv =====
// One restoring division cell: brings in one dividend bit, trial-subtracts.
// Depends on dchs_pkg.
module dchs_cell (
  input  logic [dchs_pkg::DivW-1:0] divisor,
  input  logic                      bit_in,
  input  dchs_pkg::dchs_step_t      step_in,
  output dchs_pkg::dchs_step_t      step_out
);
  import dchs_pkg::*;
  logic [DivW+1:0] trial;
  always_comb begin
    trial = {step_in.rem, bit_in} - {2'b00, divisor};
    step_out.quo = {step_in.quo[NumW-2:0], ~trial[DivW+1]};
    step_out.rem = trial[DivW+1] ? {step_in.rem[DivW-1:0], bit_in} : trial[DivW:0];
  end
endmodule

// ===== rtl/dchs_div_row.sv =====
// A row of four division cells, registered at its end; eight passes divide 32 bits.
// Depends on dchs_pkg and dchs_cell.
module dchs_div_row (
  input  logic                      clk,
  input  logic                      start,
  input  logic [dchs_pkg::NumW-1:0] dividend,
  input  logic [dchs_pkg::DivW-1:0] divisor,
  output logic                      done,
  output logic [dchs_pkg::NumW-1:0] quotient,
  output logic                      exact
);
  import dchs_pkg::*;
  localparam int unsigned Cells = 4;
  localparam int unsigned Passes = NumW / Cells;
  dchs_step_t step_r, step_nxt;
  dchs_step_t link [Cells+1];
  logic [NumW-1:0] sh_r;
  logic [3:0] cnt_r;
  assign link[0] = step_r;
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    dchs_cell u_cell (.divisor(divisor), .bit_in(sh_r[NumW-1-i]),
                      .step_in(link[i]), .step_out(link[i+1]));
  end
  assign step_nxt = link[Cells];
  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      sh_r   <= dividend;
      cnt_r  <= 4'(Passes);
    end else if (cnt_r != 4'd0) begin
      step_r <= step_nxt;
      sh_r   <= sh_r << Cells;
      cnt_r  <= cnt_r - 4'd1;
    end
  end
  assign done = (cnt_r == 4'd0) && !start;
  assign quotient = step_r.quo;
  assign exact = (step_r.rem == '0);
endmodule

// ===== rtl/disk_chs_geometry_from_sector_count.sv =====
// Top level: CHS geometry from a total sector count, streaming in and out.
// Depends on dchs_pkg and dchs_div_row.
//
//  channel | ports               | direction | contents
//  in_     | tvalid/tready/tdata | slave     | total_sectors [31:0]
//  out_    | tvalid/tready/tdata | master    | cylinders, heads, sectors, flag
//
// Each division in the four-cell row is started, runs eight passes and then has
// its result acted on by the sequencer. A word needs up to 15 head trials, 62
// track trials and a final division.
// Reset clears the sequencer and the output valid. A new word is taken once
// the previous result has moved to the output register; a stalled output holds.
module disk_chs_geometry_from_sector_count (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] total_sectors
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [14:0] cylinders, [19:15] heads,
                                  // [25:20] spt, [26] used_fallback
);
  import dchs_pkg::*;
  dchs_state_t state_r, state_nxt;
  logic [NumW-1:0] total_r, per_head_r;
  logic [DivW-1:0] div_r;
  logic [4:0] heads_r;
  logic start_r;
  logic dv_done, dv_exact;
  logic [NumW-1:0] dv_quo, dv_num;
  logic out_tvalid_r;
  logic [26:0] res_r;
  logic [26:0] out_data_r;
  logic take;

  assign take = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign dv_num = (state_r == ST_HEAD) ? total_r : per_head_r;

  dchs_div_row u_div (.clk(clk), .start(start_r), .dividend(dv_num), .divisor(div_r),
                      .done(dv_done), .quotient(dv_quo), .exact(dv_exact));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (take) state_nxt = (in_tdata >= LargeLimit) ? ST_DONE : ST_HEAD;
      ST_HEAD: if (dv_done && (dv_exact || div_r == 6'd2)) state_nxt = ST_SPT;
      ST_SPT:  if (dv_done && (dv_exact || div_r == 6'd2)) state_nxt = ST_CYL;
      ST_CYL:  if (dv_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= 1'b0;
      if (out_tvalid_r && out_tready && state_r != ST_DONE) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (take) begin
          total_r <= in_tdata;
          div_r   <= 6'd16;
          start_r <= 1'b1;
          res_r   <= {1'b1, LargeSpt, LargeHeads, LargeCyls};
        end
        ST_HEAD: if (dv_done) begin
          start_r <= 1'b1;
          if (dv_exact) begin
            heads_r <= div_r[4:0]; per_head_r <= dv_quo; div_r <= 6'd63;
          end else if (div_r == 6'd2) begin
            heads_r <= 5'd1; per_head_r <= total_r; div_r <= 6'd63;
          end else div_r <= div_r - 6'd1;
        end
        ST_SPT: if (dv_done) begin
          start_r <= 1'b1;
          if (dv_exact) begin
            // keep divisor; the next division gives the cylinder count
          end else if (div_r == 6'd2) div_r <= 6'd1;
          else div_r <= div_r - 6'd1;
        end
        ST_CYL: if (dv_done && dv_quo <= MaxCyls)
          res_r <= {1'b0, div_r, heads_r, dv_quo[14:0]};
        ST_DONE: if (!out_tvalid_r || out_tready) begin
          out_tvalid_r <= 1'b1;
          out_data_r   <= res_r;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = {5'd0, out_data_r};
endmodule
